// ===== hdl/mte_pkg.sv =====
package mte_pkg;

    // Scaling and limits
    localparam int PX_SCALE     = 2;
    localparam int PX_LIMIT     = 64;
    localparam int SCREEN_LIMIT = 239;

    // Field widths
    localparam int SIZE_W  = 4;
    localparam int ADDR_W  = 16;
    localparam int ART_W   = 64;
    localparam int COORD_W = 8;
    localparam int COLOR_W = 16;

    // Internal widths: side is size * PX_SCALE, count is side squared at full width
    localparam int SIDE_W  = 6;
    localparam int COUNT_W = 12;
    localparam int PROD_W  = COORD_W + SIDE_W;
    // Line register width in logical pixels; an accepted tile row is at most 4 wide (count <= 64 pixels)
    localparam int LINE_W  = 8;
    localparam int PX_W    = (PX_SCALE > 1) ? $clog2(PX_SCALE) : 1;

    // Stream packing
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;
    localparam int S_SIZE_LSB = 0;
    localparam int S_ADDR_LSB = S_SIZE_LSB + SIZE_W;
    localparam int S_ART_LSB  = S_ADDR_LSB + ADDR_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_COLOR  = 1'b1;

    localparam logic [COLOR_W-1:0] OFF_COLOR_RESET = 16'h0000;
    localparam logic [COLOR_W-1:0] ON_COLOR_RESET  = 16'hFFFF;

    // Window of the current tile, from the setup unit to the serialiser
    typedef struct packed {
        logic               invalid;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] y_last;
    } mte_window_t;

endpackage

// ===== hdl/mono_tile_color_expander.sv =====
// Mono tile colour expander. A tile transaction carries a size, an address and
// 1-bit art; each art bit becomes a PX_SCALE square of the on or off colour
// and the true pixels leave one per cycle while m_tready allows, in raster
// order, each carrying the screen window, with tlast on the final pixel. A
// valid tile first has its window registered by the setup unit, then the pixel
// serialiser shifts the art out one bit per PX_SCALE pixels. A zero size, too
// many pixels or an origin past 239 gives one result with tuser set, a zero
// payload and tlast. One tile is in flight at a time; the next is taken once the
// last result has entered the output register. Colours are written through the
// cfg port; the user must do so only while idle, as the block does not enforce it.
module mono_tile_color_expander (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg: 0 off_color, 1 on_color
    input  logic                            cfg_we,
    input  logic [mte_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [mte_pkg::COLOR_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // size [3:0], tile_address [19:4], art_bits [83:20], zero pad
    input  logic [mte_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // x_first [7:0], x_last [15:8], y_first [23:16], y_last [31:24], color [47:32]
    output logic [mte_pkg::M_DATA_W-1:0]    m_tdata,
    // status [0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    logic [mte_pkg::COLOR_W-1:0] off_color_reg, off_color_next;
    logic [mte_pkg::COLOR_W-1:0] on_color_reg, on_color_next;
    mte_pkg::mte_window_t        window;
    logic                        load;

    // Colour registers
    always_comb begin
        off_color_next = off_color_reg;
        on_color_next  = on_color_reg;
        if (cfg_we) begin
            case (cfg_addr)
                mte_pkg::REG_OFF_COLOR: off_color_next = cfg_wdata;
                mte_pkg::REG_ON_COLOR:  on_color_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_color_reg <= mte_pkg::OFF_COLOR_RESET;
            on_color_reg  <= mte_pkg::ON_COLOR_RESET;
        end else begin
            off_color_reg <= off_color_next;
            on_color_reg  <= on_color_next;
        end
    end

    assign load = s_tvalid && s_tready;

    mte_window u_window (
        .aclk         (aclk),
        .load         (load),
        .tile_dim     (s_tdata[mte_pkg::S_SIZE_LSB +: mte_pkg::SIZE_W]),
        .tile_address (s_tdata[mte_pkg::S_ADDR_LSB +: mte_pkg::ADDR_W]),
        .window       (window)
    );

    mte_serialiser u_serialiser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .tile_dim  (s_tdata[mte_pkg::S_SIZE_LSB +: mte_pkg::SIZE_W]),
        .art_bits  (s_tdata[mte_pkg::S_ART_LSB +: mte_pkg::ART_W]),
        .window    (window),
        .off_color (off_color_reg),
        .on_color  (on_color_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/mte_window.sv =====
module mte_window (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [mte_pkg::SIZE_W-1:0]  tile_dim,
    input  logic [mte_pkg::ADDR_W-1:0]  tile_address,
    output mte_pkg::mte_window_t        window
);

    logic                          size_zero_reg, size_zero_next;
    logic                          too_many_reg, too_many_next;
    logic [mte_pkg::COORD_W-1:0]   x0_reg, x0_next;
    logic [mte_pkg::COORD_W-1:0]   y0_reg, y0_next;
    logic [mte_pkg::SIDE_W-1:0]    side_reg, side_next;
    logic [mte_pkg::COUNT_W-1:0]   count;
    logic [mte_pkg::PROD_W-1:0]    x_prod;
    logic [mte_pkg::PROD_W-1:0]    y_prod;

    // Side, pixel count and origin products, taken at the transaction
    always_comb begin
        side_next = mte_pkg::SIDE_W'(tile_dim * mte_pkg::PX_SCALE);
        count     = mte_pkg::COUNT_W'(tile_dim * tile_dim
                                      * (mte_pkg::PX_SCALE * mte_pkg::PX_SCALE));
        x_prod    = mte_pkg::PROD_W'(tile_address[mte_pkg::ADDR_W-1 -: mte_pkg::COORD_W])
                  * mte_pkg::PROD_W'(side_next);
        y_prod    = mte_pkg::PROD_W'(tile_address[mte_pkg::COORD_W-1:0])
                  * mte_pkg::PROD_W'(side_next);
        // origin wraps to 8 bits
        x0_next        = x_prod[mte_pkg::COORD_W-1:0];
        y0_next        = y_prod[mte_pkg::COORD_W-1:0];
        size_zero_next = (tile_dim == '0);
        too_many_next  = (count > mte_pkg::COUNT_W'(mte_pkg::PX_LIMIT));
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            size_zero_reg <= size_zero_next;
            too_many_reg  <= too_many_next;
            x0_reg        <= x0_next;
            y0_reg        <= y0_next;
            side_reg      <= side_next;
        end
    end

    // Validity and window end points
    always_comb begin
        window.invalid = size_zero_reg || too_many_reg
                      || (x0_reg > mte_pkg::COORD_W'(mte_pkg::SCREEN_LIMIT))
                      || (y0_reg > mte_pkg::COORD_W'(mte_pkg::SCREEN_LIMIT));
        window.x_first = x0_reg;
        window.y_first = y0_reg;
        window.x_last  = x0_reg + mte_pkg::COORD_W'(side_reg) - mte_pkg::COORD_W'(1);
        window.y_last  = y0_reg + mte_pkg::COORD_W'(side_reg) - mte_pkg::COORD_W'(1);
    end

endmodule

// ===== hdl/mte_serialiser.sv =====
module mte_serialiser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mte_pkg::SIZE_W-1:0]    tile_dim,
    input  logic [mte_pkg::ART_W-1:0]     art_bits,
    input  mte_pkg::mte_window_t          window,
    input  logic [mte_pkg::COLOR_W-1:0]   off_color,
    input  logic [mte_pkg::COLOR_W-1:0]   on_color,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mte_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mte_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;
    logic [mte_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [mte_pkg::ART_W-1:0]     art_reg, art_next;
    logic [mte_pkg::LINE_W-1:0]    line_reg, line_next;
    logic [mte_pkg::PX_W-1:0]      px_reg, px_next;
    logic [mte_pkg::PX_W-1:0]      py_reg, py_next;
    logic [mte_pkg::SIZE_W-1:0]    lx_reg, lx_next;
    logic [mte_pkg::SIZE_W-1:0]    ly_reg, ly_next;
    logic [mte_pkg::ART_W-1:0]     art_shift;
    logic                          advance;
    logic                          px_end, py_end, row_end, tile_end;
    logic [mte_pkg::COLOR_W-1:0]   pix_color;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign advance  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // Position within the tile
    always_comb begin
        px_end    = (px_reg == mte_pkg::PX_W'(mte_pkg::PX_SCALE - 1));
        py_end    = (py_reg == mte_pkg::PX_W'(mte_pkg::PX_SCALE - 1));
        row_end   = px_end && (lx_reg == size_reg - mte_pkg::SIZE_W'(1));
        tile_end  = row_end && py_end && (ly_reg == size_reg - mte_pkg::SIZE_W'(1));
        art_shift = art_reg << size_reg;
        pix_color = line_reg[mte_pkg::LINE_W-1] ? on_color : off_color;
    end

    // Load, shift and emit
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        size_next    = size_reg;
        art_next     = art_reg;
        line_next    = line_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    size_next  = tile_dim;
                    art_next   = art_bits;
                    line_next  = art_bits[mte_pkg::ART_W-1 -: mte_pkg::LINE_W];
                    px_next    = '0;
                    py_next    = '0;
                    lx_next    = '0;
                    ly_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    if (window.invalid) begin
                        m_user_next = 1'b1;
                        m_data_next = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        m_user_next = 1'b0;
                        m_data_next = {pix_color, window.y_last, window.y_first,
                                       window.x_last, window.x_first};
                        m_last_next = tile_end;
                        if (tile_end) begin
                            state_next = ST_IDLE;
                        end
                        if (row_end) begin
                            px_next = '0;
                            lx_next = '0;
                            if (py_end) begin
                                // next logical row
                                py_next   = '0;
                                ly_next   = ly_reg + mte_pkg::SIZE_W'(1);
                                art_next  = art_shift;
                                line_next = art_shift[mte_pkg::ART_W-1 -: mte_pkg::LINE_W];
                            end else begin
                                // repeat the same logical row
                                py_next   = py_reg + mte_pkg::PX_W'(1);
                                line_next = art_reg[mte_pkg::ART_W-1 -: mte_pkg::LINE_W];
                            end
                        end else if (px_end) begin
                            px_next   = '0;
                            lx_next   = lx_reg + mte_pkg::SIZE_W'(1);
                            line_next = line_reg << 1;
                        end else begin
                            px_next = px_reg + mte_pkg::PX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        size_reg   <= size_next;
        art_reg    <= art_next;
        line_reg   <= line_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // An invalid tile gives a single, closing result
    a_invalid_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg |-> m_last_reg)
        else $error("invalid result without last");

    // An invalid result carries an empty window and colour
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg |-> (m_data_reg == '0))
        else $error("invalid result with non-zero payload");

    // One tile at a time: no transaction straight after another
    a_one_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a tile is in flight");

endmodule
